/* hdl/dcd_pkg.sv */
// ----------------------------------------------------------------------------
// dcd_pkg
// Types and constants used by the delta coordinate decoder.
// ----------------------------------------------------------------------------
package dcd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_COORD_BYTES = 2'd0;
  localparam logic [1:0] CFG_REF_X       = 2'd1;
  localparam logic [1:0] CFG_REF_Y       = 2'd2;

  // input word kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // bytes per axis codes
  localparam logic [2:0] AXIS_2B = 3'd2;
  localparam logic [2:0] AXIS_3B = 3'd3;

  // run status values
  localparam logic [2:0] STATUS_END      = 3'd4;
  localparam logic [2:0] STATUS_WITHHELD = 3'd5;
  localparam logic [2:0] STATUS_STEP     = 3'd2;

  typedef struct packed {
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic        flagged;
    logic        coord_valid;
    logic        resume_point;
    logic        done_res;
  } res_t;

endpackage

/* hdl/delta_coordinate_decoder.sv */
// ----------------------------------------------------------------------------
// delta_coordinate_decoder
// Assembles little-endian x/y vertex fields from a byte stream, undoes the
// marker encoding on x, adds the reference corner and tracks the run status.
// A vertex word is registered into the output queue when its last byte is taken.
// Throughput: one input word per cycle while in_stall is low; a two-word output queue (register
// plus skid) lets input flow while a result waits.
// Reset: synchronous, active low; clears status, byte count, queue and
// configuration (2 bytes per axis, zero reference).
// ----------------------------------------------------------------------------
module delta_coordinate_decoder (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_status,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic               out_flagged,
  output logic               out_coord_valid,
  output logic               out_resume_point,
  output logic               out_done_res
);

  logic [2:0]         coord_bytes_r;
  logic [31:0]        ref_x_r;
  logic [31:0]        ref_y_r;

  logic [2:0]         status_r;
  logic [2:0]         idx_r;
  logic [63:0]        asm_r;

  dcd_pkg::res_t      head_r, skid_r;
  logic               head_v_r, skid_v_r;

  logic               acc;
  logic               pop;
  logic               push;
  logic               is_data;
  logic               live;
  logic [2:0]         idx_inc;
  logic [3:0]         total;
  logic               complete;
  logic [63:0]        asm_cur;
  logic [31:0]        x_raw, y_raw, x_mag, x_dec;
  logic               flag;
  logic [2:0]         status_step;
  logic [2:0]         status_nxt;
  dcd_pkg::res_t      res;

  assign acc     = in_valid && !in_stall;
  assign pop     = head_v_r && !out_stall;
  assign is_data = (in_kind == dcd_pkg::KIND_DATA);
  assign live    = is_data && (status_r < dcd_pkg::STATUS_END);

  // place the new byte into the assembly word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      asm_cur[i*8 +: 8] = asm_r[i*8 +: 8] | ((idx_r == 3'(i)) ? in_data_byte : 8'h00);
    end
  end

  assign idx_inc = idx_r + 3'd1;

  always_comb begin
    case (coord_bytes_r)
      dcd_pkg::AXIS_2B: begin
        total = 4'd4;
        x_raw = {16'h0000, asm_cur[15:0]};
        y_raw = {16'h0000, asm_cur[31:16]};
        flag  = asm_cur[15];
        x_mag = {16'h0000, 16'(16'h0000 - asm_cur[15:0])};
      end
      dcd_pkg::AXIS_3B: begin
        total = 4'd6;
        x_raw = {8'h00, asm_cur[23:0]};
        y_raw = {8'h00, asm_cur[47:24]};
        flag  = asm_cur[23];
        x_mag = {8'h00, 24'(24'h000000 - asm_cur[23:0])};
      end
      default: begin
        total = 4'd8;
        x_raw = asm_cur[31:0];
        y_raw = asm_cur[63:32];
        flag  = asm_cur[31];
        x_mag = 32'h0000_0000 - asm_cur[31:0];
      end
    endcase
  end

  // a wrap of the byte count also closes the vertex
  assign complete    = (idx_inc == 3'd0) || ({1'b0, idx_inc} >= total);
  assign x_dec       = flag ? x_mag : x_raw;
  assign status_step = status_r + dcd_pkg::STATUS_STEP;
  assign status_nxt  = flag ? status_step : status_r;

  always_comb begin
    res.coord_x      = ref_x_r + x_dec;
    res.coord_y      = ref_y_r + y_raw;
    res.flagged      = flag;
    res.coord_valid  = !(flag && (status_step == dcd_pkg::STATUS_WITHHELD));
    res.resume_point = flag && (status_r != 3'd0);
    res.done_res     = flag && (status_step >= dcd_pkg::STATUS_END);
  end

  assign push = acc && live && complete;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_bytes_r <= dcd_pkg::AXIS_2B;
      ref_x_r       <= '0;
      ref_y_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dcd_pkg::CFG_COORD_BYTES: coord_bytes_r <= cfg_data[2:0];
        dcd_pkg::CFG_REF_X:       ref_x_r       <= cfg_data;
        dcd_pkg::CFG_REF_Y:       ref_y_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      idx_r    <= '0;
      asm_r    <= '0;
    end else if (acc) begin
      if (!is_data) begin
        status_r <= {2'b00, in_start_status};
        idx_r    <= '0;
        asm_r    <= '0;
      end else if (live) begin
        if (complete) begin
          status_r <= status_nxt;
          idx_r    <= '0;
          asm_r    <= '0;
        end else begin
          idx_r    <= idx_inc;
          asm_r    <= asm_cur;
        end
      end
      // drop bytes after the end of the polyline
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= res;
        end else begin
          skid_v_r <= 1'b0;
        end
      end else if (push) begin
        head_r <= res;
      end else begin
        head_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_r   <= res;
        head_v_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end
  end

  assign in_stall         = skid_v_r;
  assign out_valid        = head_v_r;
  assign out_coord_x      = head_r.coord_x;
  assign out_coord_y      = head_r.coord_y;
  assign out_flagged      = head_r.flagged;
  assign out_coord_valid  = head_r.coord_valid;
  assign out_resume_point = head_r.resume_point;
  assign out_done_res     = head_r.done_res;

endmodule

/* hdl/dcd_checker.sv */
// ----------------------------------------------------------------------------
// dcd_checker
// Port-level checks for the delta coordinate decoder.
// ----------------------------------------------------------------------------
module dcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_coord_x,
  input logic signed [31:0] out_coord_y,
  input logic               out_flagged,
  input logic               out_coord_valid,
  input logic               out_resume_point,
  input logic               out_done_res
);

  // input only backs up once both output slots hold a word
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no word waiting");

  // end, resume and withhold only come from a flagged vertex
  a_flag_rules: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!out_done_res || out_flagged) && (!out_resume_point || out_flagged)))
    else $error("done or resume without flag");

  a_withheld_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_coord_valid) |-> out_done_res)
    else $error("withheld vertex does not end the polyline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_coord_x) && $stable(out_coord_y)))
    else $error("stalled word changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("queue not empty after reset");

endmodule

bind delta_coordinate_decoder dcd_checker u_dcd_checker (.*);
